// ===== hdl/ntpg_pkg.sv =====
// ============================================================================
// ntpg_pkg
// Shared types and constants of the nth prime table generator.
// ============================================================================
`default_nettype none

package ntpg_pkg;

   // Default sizes of the prime table and of one stored prime.
   localparam int TABLE_DEPTH_DEFAULT = 8192;
   localparam int PRIME_WIDTH_DEFAULT = 17;

   // Width of the requested index as it arrives on the request channel.
   localparam int INDEX_WIDTH = 14;

   // Number of table entries that hold fixed seed primes.
   localparam int SEED_COUNT = 3;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EXT_CHECK,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_TRIAL_EVAL,
      ST_RESULT,
      ST_RESULT_ERR
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_index;
      logic start_extension;
      logic begin_trials;
      logic load_divisor;
      logic read_next;
      logic reject;
      logic append;
      logic read_out;
      logic load_result;
      logic result_error;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic index_valid;
      logic covered;
      logic cand_too_big;
      logic div_busy;
      logic divisor_zero;
      logic rem_zero;
      logic square_exceeds;
      logic last_divisor;
      logic out_free;
   } status_type;

   // Seed primes held in the first table entries: 2, 3 and 5.
   function automatic logic [31:0] seed_prime(input logic [1:0] k);
      logic [31:0] value;
      case (k)
         2'd0: value = 32'd2;
         2'd1: value = 32'd3;
         2'd2: value = 32'd5;
         default: value = 32'd0;
      endcase
      return value;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ntpg_rem_unit.sv =====
// ============================================================================
// ntpg_rem_unit
// Bit-serial restoring remainder unit: one dividend bit per clock cycle.
// ============================================================================
`default_nettype none

module ntpg_rem_unit #(
   parameter int PRIME_WIDTH = 17
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [PRIME_WIDTH-1:0] dividend,
   input  wire logic [PRIME_WIDTH-1:0] divisor,
   output logic                        busy,
   output logic [PRIME_WIDTH-1:0]      remainder
);
   import ntpg_pkg::*;

   localparam int CNT_W = $clog2(PRIME_WIDTH + 1);

   logic                   busy_ff, busy_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [PRIME_WIDTH-1:0] dvd_ff, dvd_in;
   logic [PRIME_WIDTH-1:0] div_ff, div_in;
   logic [PRIME_WIDTH:0]   rem_ff, rem_in;
   logic [PRIME_WIDTH:0]   trial;

   // Shift in the next dividend bit and subtract the divisor when it fits.
   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      dvd_in   = dvd_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      trial    = {rem_ff[PRIME_WIDTH-1:0], dvd_ff[PRIME_WIDTH-1]};
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(PRIME_WIDTH);
         dvd_in   = dividend;
         div_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
         end else begin
            rem_in = trial;
         end
         dvd_in   = {dvd_ff[PRIME_WIDTH-2:0], 1'b0};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   // Operand and remainder registers.
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff[PRIME_WIDTH-1:0];

endmodule

`default_nettype wire

// ===== hdl/ntpg_ctrl.sv =====
// ============================================================================
// ntpg_ctrl
// Controller of the prime generator: sequences lookups and table extension.
// ============================================================================
`default_nettype none

module ntpg_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire ntpg_pkg::status_type status,
   output ntpg_pkg::cmd_type        cmd
);
   import ntpg_pkg::*;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_index = 1'b1;
               state_in       = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.index_valid) begin
               state_in = ST_RESULT_ERR;
            end else if (status.covered) begin
               cmd.read_out = 1'b1;
               state_in     = ST_RESULT;
            end else begin
               cmd.start_extension = 1'b1;
               state_in            = ST_EXT_CHECK;
            end
         end
         ST_EXT_CHECK: begin
            if (status.covered) begin
               cmd.read_out = 1'b1;
               state_in     = ST_RESULT;
            end else if (status.cand_too_big) begin
               state_in = ST_RESULT_ERR;
            end else begin
               cmd.begin_trials = 1'b1;
               state_in         = ST_DIV_LOAD;
            end
         end
         ST_DIV_LOAD: begin
            cmd.load_divisor = 1'b1;
            state_in         = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (!status.div_busy) begin
               state_in = ST_TRIAL_EVAL;
            end
         end
         ST_TRIAL_EVAL: begin
            if (status.divisor_zero || status.rem_zero) begin
               cmd.reject = 1'b1;
               state_in   = ST_EXT_CHECK;
            end else if (status.square_exceeds || status.last_divisor) begin
               cmd.append = 1'b1;
               state_in   = ST_EXT_CHECK;
            end else begin
               cmd.read_next = 1'b1;
               state_in      = ST_DIV_LOAD;
            end
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_RESULT_ERR: begin
            if (status.out_free) begin
               cmd.load_result  = 1'b1;
               cmd.result_error = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/ntpg_datapath.sv =====
// ============================================================================
// ntpg_datapath
// Prime table, candidate and divisor registers, and the result register.
// ============================================================================
`default_nettype none

module ntpg_datapath #(
   parameter int TABLE_DEPTH = 8192,
   parameter int PRIME_WIDTH = 17
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [ntpg_pkg::INDEX_WIDTH-1:0] req_index,
   input  wire ntpg_pkg::cmd_type                cmd,
   output ntpg_pkg::status_type                  status,
   input  wire logic                             rsp_tready,
   output logic                                  rsp_tvalid,
   output logic [PRIME_WIDTH-1:0]                prime_value,
   output logic                                  index_error
);
   import ntpg_pkg::*;

   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int CMPW = (CW > INDEX_WIDTH) ? CW : INDEX_WIDTH;
   localparam int SQW  = 2 * PRIME_WIDTH;

   // Prime table; the seed entries are served from constants.
   logic [PRIME_WIDTH-1:0] prime_mem [TABLE_DEPTH];

   logic [INDEX_WIDTH-1:0] index_ff;
   logic [CW-1:0]          known_ff;
   logic [PRIME_WIDTH-1:0] last_ff;
   logic [PRIME_WIDTH:0]   cand_ff;
   logic [AW-1:0]          div_idx_ff;
   logic [PRIME_WIDTH-1:0] rd_data_ff;
   logic                   rd_seed_ff;
   logic [PRIME_WIDTH-1:0] rd_seed_val_ff;
   logic [SQW-1:0]         square_ff;
   logic                   divisor_zero_ff;
   logic                   out_valid_ff;
   logic [PRIME_WIDTH-1:0] out_value_ff;
   logic                   out_error_ff;

   logic [CMPW-1:0]        index_ext;
   logic [CMPW-1:0]        index_less_one;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [PRIME_WIDTH-1:0] rd_value;
   logic                   div_busy;
   logic [PRIME_WIDTH-1:0] remainder;

   assign index_ext      = CMPW'(index_ff);
   assign index_less_one = index_ext - CMPW'(1);

   // Read address: first divisor, next divisor, or the requested entry.
   always_comb begin
      rd_en   = cmd.begin_trials | cmd.read_next | cmd.read_out;
      rd_addr = index_less_one[AW-1:0];
      if (cmd.begin_trials) begin
         rd_addr = AW'(1);
      end else if (cmd.read_next) begin
         rd_addr = div_idx_ff + AW'(1);
      end
   end

   // Memory read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff     <= prime_mem[rd_addr];
         rd_seed_ff     <= (rd_addr < AW'(SEED_COUNT));
         rd_seed_val_ff <= PRIME_WIDTH'(seed_prime(rd_addr[1:0]));
      end
   end

   // Memory write port: a new prime goes behind the known ones.
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         prime_mem[known_ff[AW-1:0]] <= cand_ff[PRIME_WIDTH-1:0];
      end
   end

   assign rd_value = rd_seed_ff ? rd_seed_val_ff : rd_data_ff;

   // Table bookkeeping: count of known primes and the largest one.
   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= CW'(SEED_COUNT);
         last_ff  <= PRIME_WIDTH'(seed_prime(2'd2));
      end else if (cmd.append) begin
         known_ff <= known_ff + CW'(1);
         last_ff  <= cand_ff[PRIME_WIDTH-1:0];
      end
   end

   // Request index, candidate and divisor position.
   always_ff @(posedge clock) begin
      if (cmd.load_index) begin
         index_ff <= req_index;
      end
      if (cmd.start_extension) begin
         cand_ff <= {1'b0, last_ff} + (PRIME_WIDTH + 1)'(2);
      end else if (cmd.reject || cmd.append) begin
         cand_ff <= cand_ff + (PRIME_WIDTH + 1)'(2);
      end
      if (cmd.begin_trials) begin
         div_idx_ff <= AW'(1);
      end else if (cmd.read_next) begin
         div_idx_ff <= div_idx_ff + AW'(1);
      end
      if (cmd.load_divisor) begin
         square_ff       <= SQW'(rd_value) * SQW'(rd_value);
         divisor_zero_ff <= (rd_value == '0);
      end
   end

   // Trial division of the candidate by the current divisor.
   ntpg_rem_unit #(
      .PRIME_WIDTH (PRIME_WIDTH)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.load_divisor),
      .dividend  (cand_ff[PRIME_WIDTH-1:0]),
      .divisor   (rd_value),
      .busy      (div_busy),
      .remainder (remainder)
   );

   // Result register: a finished word waits here until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_result) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         out_value_ff <= cmd.result_error ? '0 : rd_value;
         out_error_ff <= cmd.result_error;
      end
   end

   // Status toward the controller.
   always_comb begin
      status.index_valid    = (index_ff != '0) && (index_ext <= CMPW'(TABLE_DEPTH));
      status.covered        = (CMPW'(known_ff) >= index_ext);
      status.cand_too_big   = cand_ff[PRIME_WIDTH];
      status.div_busy       = div_busy;
      status.divisor_zero   = divisor_zero_ff;
      status.rem_zero       = (remainder == '0);
      status.square_exceeds = (square_ff > SQW'(cand_ff));
      status.last_divisor   = ((CW'(div_idx_ff) + CW'(1)) >= known_ff);
      status.out_free       = !out_valid_ff || rsp_tready;
   end

   assign rsp_tvalid  = out_valid_ff;
   assign prime_value = out_value_ff;
   assign index_error = out_error_ff;

endmodule

`default_nettype wire

// ===== hdl/nth_prime_table_generator_top.sv =====
// ============================================================================
// nth_prime_table_generator_top
// Returns the n-th prime, growing a table of primes by trial division.
// ============================================================================
// A request word carries a 1-based prime index; the response word carries
// that prime and an error flag (index zero, index past TABLE_DEPTH, or no
// further prime fits in PRIME_WIDTH bits). One request is worked on at a
// time. An index already in the table is answered from the table. Otherwise the
// table grows one odd candidate at a time: the single table read port
// supplies one divisor per trial, and the remainder unit takes one dividend
// bit per cycle. Divisors are tried from 3 upward until one divides the
// candidate, its square exceeds it, or no stored divisor is left. The seed
// primes 2, 3 and 5 are constants, so no clearing pass follows reset. A
// finished response is held in an output register while the block waits.
`default_nettype none

module nth_prime_table_generator_top #(
   parameter int TABLE_DEPTH = ntpg_pkg::TABLE_DEPTH_DEFAULT,
   parameter int PRIME_WIDTH = ntpg_pkg::PRIME_WIDTH_DEFAULT,
   localparam int RSP_DATA_W = ((PRIME_WIDTH + 7) / 8) * 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,   // [13:0] prime_index
   // Response channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [PRIME_WIDTH-1:0] prime_value
   output logic                       rsp_tuser    // [0] index_error
);
   import ntpg_pkg::*;

   cmd_type                cmd;
   status_type             status;
   logic [PRIME_WIDTH-1:0] prime_value;

   // Sequencer.
   ntpg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Table, trial division and response register.
   ntpg_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .PRIME_WIDTH (PRIME_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_index   (req_tdata[INDEX_WIDTH-1:0]),
      .cmd         (cmd),
      .status      (status),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .prime_value (prime_value),
      .index_error (rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_W'(prime_value);

endmodule

`default_nettype wire
